### hw/rtl/chds_pkg.sv
`timescale 1ns / 1ps
package chds_pkg;

  // Default output fraction width.
  localparam int FracBitsDefault = 16;

  // Internal angle and series precision.
  localparam int QBits = 30;

  // Width of the unsigned sample fields.
  localparam int UBits = 16;

  // Width of a sample magnitude, which runs up to 2^16.
  localparam int MagBits = 17;

  // Width of a Q30 value that may reach one.
  localparam int Q30Bits = 31;

  // Pi over four in Q30.
  localparam logic [Q30Bits-1:0] Pi4Q30 = 31'd843314857;

  // Divider cells after the top ratio bit: one quotient bit per cycle.
  localparam int DivSteps = 30;

  // Taylor series divisors, sine first, then cosine.
  localparam int SinTerms = 5;
  localparam int CosTerms = 6;

  // Sine divisor for a given series step.
  function automatic logic [7:0] sin_div(input int idx);
    logic [7:0] d;
    begin
      case (idx)
        0: d = 8'd110;
        1: d = 8'd72;
        2: d = 8'd42;
        3: d = 8'd20;
        default: d = 8'd6;
      endcase
      return d;
    end
  endfunction

  // Cosine divisor for a given series step.
  function automatic logic [7:0] cos_div(input int idx);
    logic [7:0] d;
    begin
      case (idx)
        0: d = 8'd132;
        1: d = 8'd90;
        2: d = 8'd56;
        3: d = 8'd30;
        4: d = 8'd12;
        default: d = 8'd2;
      endcase
      return d;
    end
  endfunction

  // Values carried from one cell of the chain to the next.
  typedef struct packed {
    logic                  vld;
    logic                  ctr;
    logic                  first;
    logic                  neg_a;
    logic                  neg_b;
    logic [MagBits-1:0]    m;
    logic [MagBits-1:0]    n;
    logic [Q30Bits-1:0]    quo;
    logic [Q30Bits+17:0]   rem;
  } chds_div_t;

endpackage

### hw/rtl/chds_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step: a single quotient bit of n * 2^30 / m.
module chds_div_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  chds_pkg::chds_div_t  din,
  output chds_pkg::chds_div_t  dout
);

  localparam int RW = chds_pkg::Q30Bits + 18;

  logic [RW-1:0] shifted;
  logic [RW-1:0] mext;
  logic          take;

  // Shift the partial remainder and try subtracting the divisor.
  always_comb begin
    shifted = {din.rem[RW-2:0], 1'b0};
    mext    = {{(RW-chds_pkg::MagBits){1'b0}}, din.m};
    take    = shifted >= mext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.ctr   <= din.ctr;
    dout.first <= din.first;
    dout.neg_a <= din.neg_a;
    dout.neg_b <= din.neg_b;
    dout.m     <= din.m;
    dout.n     <= din.n;
    dout.quo   <= {din.quo[chds_pkg::Q30Bits-2:0], take};
    dout.rem   <= take ? (shifted - mext) : shifted;
  end

endmodule

### hw/rtl/chds_series_cell.sv
`timescale 1ns / 1ps
// One Horner step of a Taylor series: t <= 1 - ((x2 * t) >> 30) / DIV.
// The product is registered before the constant division, which is done
// as a multiplication by a rounded-up reciprocal, exact for 31-bit products.
module chds_series_cell #(
  parameter int DIV = 2
) (
  input  logic                              clk,
  input  logic [chds_pkg::Q30Bits-1:0]      x2,
  input  logic [chds_pkg::Q30Bits-1:0]      t_in,
  output logic [chds_pkg::Q30Bits-1:0]      t_out
);

  localparam int QW = chds_pkg::Q30Bits;
  localparam logic [QW-1:0] One = QW'(64'd1 << chds_pkg::QBits);
  localparam int DivShift = QW + $clog2(DIV);
  localparam longint unsigned RecipVal = ((64'd1 << DivShift) / DIV) + 64'd1;
  localparam logic [QW:0] Recip = (QW+1)'(RecipVal);

  logic [2*QW-1:0] full;
  logic [QW-1:0]   prod;
  logic [63:0]     qfull;
  logic [QW-1:0]   quo;

  // First stage: product truncated to Q30.
  always_comb begin
    full = x2 * t_in;
  end

  // Second stage: quotient by reciprocal multiplication.
  always_comb begin
    qfull = {{(64-QW){1'b0}}, prod} * {{(63-QW){1'b0}}, Recip};
    quo   = QW'(qfull >> DivShift);
  end

  always_ff @(posedge clk) begin
    prod  <= full[chds_pkg::QBits +: QW];
    t_out <= One - quo;
  end

endmodule

### hw/rtl/cosine_hemisphere_direction_sampler.sv
`timescale 1ns / 1ps
// Cosine-weighted hemisphere direction sampler, concentric disk mapping.
//
// Request channel: u_first and u_second are taken at a rising edge with start
// high and busy low. busy is always low, so a request may come every cycle.
// Result channel: dir_x, dir_y, dir_z appear for exactly one cycle with done
// high; the receiver cannot stall, so nothing is ever held back.
//
// done rises once a request has passed every stage of the chain. The top ratio
// bit is found at the input, then a 30-cell divider chain (one ratio bit per
// cell), the angle multiply and square, the cosine Horner cells (with the
// sine running alongside), the sine multiply, scaling, rounding and squaring
// registers, the radicand register, an 18-cell square-root chain (one root
// bit per cell) and the output register. Throughput is one request per cycle:
// every cell hands its work to the next on each edge.
//
// Reset clears all valid flags in the chain; data in flight is dropped and
// no done pulse follows until new requests arrive.
module cosine_hemisphere_direction_sampler #(
  parameter int FRAC_BITS = chds_pkg::FracBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [15:0]            u_first,
  input  logic [15:0]            u_second,
  output logic                   done,
  output logic [FRAC_BITS+1:0]   dir_x,
  output logic [FRAC_BITS+1:0]   dir_y,
  output logic [FRAC_BITS:0]     dir_z
);

  localparam int QW  = chds_pkg::Q30Bits;
  localparam int MB  = chds_pkg::MagBits;
  localparam int ND  = chds_pkg::DivSteps;
  localparam int NS  = chds_pkg::SinTerms;
  localparam int NC  = chds_pkg::CosTerms;
  localparam int SH  = 46 - FRAC_BITS;
  localparam int OW  = FRAC_BITS + 2;
  localparam int SQW = 2 * FRAC_BITS + 4;
  localparam int RB  = FRAC_BITS + 2;
  // Delay that matches the series cells; the cosine has the longer chain.
  localparam int SerLat = 2 * NC;
  localparam logic [QW-1:0] One = QW'(64'd1 << chds_pkg::QBits);

  assign busy = 1'b0;

  // ---------------- Front end: fold samples ----------------
  logic signed [MB:0] a_s;
  logic signed [MB:0] b_s;
  logic [MB-1:0]      abs_a;
  logic [MB-1:0]      abs_b;
  chds_pkg::chds_div_t div_in;

  always_comb begin
    a_s   = $signed({1'b0, u_first, 1'b0}) - $signed((MB+1)'(65536));
    b_s   = $signed({1'b0, u_second, 1'b0}) - $signed((MB+1)'(65536));
    abs_a = a_s[MB] ? MB'(-a_s) : MB'(a_s);
    abs_b = b_s[MB] ? MB'(-b_s) : MB'(b_s);
    div_in.vld   = start;
    div_in.ctr   = (abs_a == '0) && (abs_b == '0);
    div_in.first = abs_a > abs_b;
    div_in.neg_a = a_s[MB];
    div_in.neg_b = b_s[MB];
    div_in.m     = div_in.first ? abs_a : abs_b;
    div_in.n     = div_in.first ? abs_b : abs_a;
    if (div_in.ctr) begin
      div_in.m = MB'(1);
    end
    // Since n <= m, the top ratio bit is set only for equal magnitudes;
    // the cells then find the lower bits from the remainder.
    div_in.quo = {{(QW-1){1'b0}}, (div_in.n == div_in.m)};
    div_in.rem = (div_in.n == div_in.m) ? '0 : {{(QW+18-MB){1'b0}}, div_in.n};
  end

  // ---------------- Divider chain ----------------
  chds_pkg::chds_div_t div_c [ND+1];
  assign div_c[0] = div_in;

  genvar gi;
  generate
    for (gi = 0; gi < ND; gi++) begin : g_div
      chds_div_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .din  (div_c[gi]),
        .dout (div_c[gi+1])
      );
    end
  endgenerate

  // ---------------- Angle ----------------
  typedef struct packed {
    logic          vld;
    logic          ctr;
    logic          first;
    logic          neg_a;
    logic          neg_b;
    logic [MB-1:0] m;
  } side_t;

  side_t          ang_sd;
  logic [QW-1:0]  phi;
  logic [2*QW-1:0] phi_full;
  always_comb begin
    phi_full = div_c[ND].quo * chds_pkg::Pi4Q30;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      ang_sd.vld <= 1'b0;
    end else begin
      ang_sd.vld <= div_c[ND].vld;
    end
    ang_sd.ctr   <= div_c[ND].ctr;
    ang_sd.first <= div_c[ND].first;
    ang_sd.neg_a <= div_c[ND].neg_a;
    ang_sd.neg_b <= div_c[ND].neg_b;
    ang_sd.m     <= div_c[ND].m;
    phi          <= phi_full[chds_pkg::QBits +: QW];
  end

  // Square of the angle; it heads the delay lines of the series cells.
  logic [QW-1:0]   x2_line  [SerLat-1];
  logic [QW-1:0]   phi_line [SerLat+1];
  side_t           sd_line  [SerLat+1];
  logic [2*QW-1:0] x2_full;
  always_comb begin
    x2_full = phi * phi;
  end
  always_ff @(posedge clk) begin
    sd_line[0]  <= rst ? '0 : ang_sd;
    x2_line[0]  <= x2_full[chds_pkg::QBits +: QW];
    phi_line[0] <= phi;
  end

  // ---------------- Series cells ----------------
  // Each step registers its product, then its result, so x2 and phi travel along a delay line.
  generate
    for (gi = 0; gi < SerLat; gi++) begin : g_line
      always_ff @(posedge clk) begin
        phi_line[gi+1] <= phi_line[gi];
        sd_line[gi+1]  <= rst ? '0 : sd_line[gi];
      end
    end
    for (gi = 0; gi < SerLat - 2; gi++) begin : g_x2
      always_ff @(posedge clk) begin
        x2_line[gi+1] <= x2_line[gi];
      end
    end
  endgenerate

  logic [QW-1:0] cos_t  [NC+1];
  logic [QW-1:0] sin_t  [NS+1];
  assign cos_t[0] = One;
  assign sin_t[0] = One;

  generate
    for (gi = 0; gi < NC; gi++) begin : g_cos
      chds_series_cell #(.DIV(int'(chds_pkg::cos_div(gi)))) u_c (
        .clk     (clk),
        .x2      (x2_line[2*gi]),
        .t_in    (cos_t[gi]),
        .t_out   (cos_t[gi+1])
      );
    end
    // The sine has one term fewer, so its chain starts one step later and
    // ends with the cosine.
    for (gi = 0; gi < NS; gi++) begin : g_sin
      chds_series_cell #(.DIV(int'(chds_pkg::sin_div(gi)))) u_s (
        .clk     (clk),
        .x2      (x2_line[2*gi+2]),
        .t_in    (sin_t[gi]),
        .t_out   (sin_t[gi+1])
      );
    end
  endgenerate

  // Sine is phi * t; cosine is registered alongside.
  logic [2*QW-1:0] sin_full;
  logic [QW-1:0]   sin_v;
  logic [QW-1:0]   cos_v;
  side_t           sc_sd;
  always_comb begin
    sin_full = phi_line[SerLat] * sin_t[NS];
  end
  always_ff @(posedge clk) begin
    sin_v <= sin_full[chds_pkg::QBits +: QW];
    cos_v <= cos_t[NC];
    sc_sd <= rst ? '0 : sd_line[SerLat];
  end

  // ---------------- Scale and round ----------------
  logic [QW+MB-1:0] px_full;
  logic [QW+MB-1:0] py_full;
  logic [QW+MB-1:0] mag_x46;
  logic [QW+MB-1:0] mag_y46;
  side_t            sc2_sd;
  always_comb begin
    px_full = sc_sd.m * (sc_sd.first ? cos_v : sin_v);
    py_full = sc_sd.m * (sc_sd.first ? sin_v : cos_v);
  end
  always_ff @(posedge clk) begin
    mag_x46 <= px_full;
    mag_y46 <= py_full;
    sc2_sd  <= rst ? '0 : sc_sd;
  end

  logic [QW+MB-1:0] rx;
  logic [QW+MB-1:0] ry;
  logic [OW-1:0]    mx;
  logic [OW-1:0]    my;
  side_t            rd_sd;
  always_comb begin
    rx = (mag_x46 + ((QW+MB)'(1) << (SH - 1))) >> SH;
    ry = (mag_y46 + ((QW+MB)'(1) << (SH - 1))) >> SH;
  end
  always_ff @(posedge clk) begin
    mx    <= sc2_sd.ctr ? '0 : OW'(rx);
    my    <= sc2_sd.ctr ? '0 : OW'(ry);
    rd_sd <= rst ? '0 : sc2_sd;
  end

  // Squares, one multiplier each, then the sum and clamp.
  logic [2*OW-1:0] sqx;
  logic [2*OW-1:0] sqy;
  logic [OW-1:0]   mx_d;
  logic [OW-1:0]   my_d;
  side_t           sq2_sd;
  always_ff @(posedge clk) begin
    sqx    <= mx * mx;
    sqy    <= my * my;
    mx_d   <= mx;
    my_d   <= my;
    sq2_sd <= rst ? '0 : rd_sd;
  end

  logic [2*OW:0]  sum_sq;
  logic [SQW-1:0] rad;
  localparam logic [2*OW:0] OneSq = (2*OW+1)'(1) << (2 * FRAC_BITS);
  always_comb begin
    sum_sq = {1'b0, sqx} + {1'b0, sqy};
    rad    = (sum_sq >= OneSq) ? '0 : SQW'((OneSq - sum_sq) << 2);
  end

  // ---------------- Square root chain ----------------
  typedef struct packed {
    logic            vld;
    logic            neg_a;
    logic            neg_b;
    logic            ctr;
    logic [OW-1:0]   mx;
    logic [OW-1:0]   my;
    logic [SQW-1:0]  v;
    logic [RB-1:0]   root;
  } sq_t;

  sq_t sr [RB+1];
  always_ff @(posedge clk) begin
    sr[0].vld   <= rst ? 1'b0 : sq2_sd.vld;
    sr[0].neg_a <= sq2_sd.neg_a;
    sr[0].neg_b <= sq2_sd.neg_b;
    sr[0].ctr   <= sq2_sd.ctr;
    sr[0].mx    <= mx_d;
    sr[0].my    <= my_d;
    sr[0].v     <= rad;
    sr[0].root  <= '0;
  end

  generate
    for (gi = 0; gi < RB; gi++) begin : g_sqrt
      localparam int B = RB - 1 - gi;
      logic [SQW+1:0] trial;
      logic [SQW+1:0] cur;
      sq_t            nxt;
      // Try setting root bit B against the remaining radicand.
      always_comb begin
        cur   = {2'b00, sr[gi].v};
        trial = ({{(SQW+2-RB){1'b0}}, sr[gi].root} << (B + 1)) +
                ((SQW+2)'(1) << (2 * B));
        nxt   = sr[gi];
        if (cur >= trial) begin
          nxt.v       = SQW'(cur - trial);
          nxt.root[B] = 1'b1;
        end
      end
      always_ff @(posedge clk) begin
        sr[gi+1] <= rst ? '0 : nxt;
      end
    end
  endgenerate

  // ---------------- Output register ----------------
  logic [RB-1:0] zr;
  always_comb begin
    zr = (sr[RB].root + RB'(1)) >> 1;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sr[RB].vld;
    end
    dir_x <= sr[RB].neg_a ? OW'(-sr[RB].mx) : sr[RB].mx;
    dir_y <= sr[RB].neg_b ? OW'(-sr[RB].my) : sr[RB].my;
    dir_z <= sr[RB].ctr ? (FRAC_BITS+1)'(1) << FRAC_BITS : (FRAC_BITS+1)'(zr);
  end

endmodule
